FILE: rtl/modbus_rtu_register_slave_macros.svh
// assertion helpers included by the top-level rtl file
`ifndef MODBUS_RTU_REGISTER_SLAVE_MACROS_SVH
`define MODBUS_RTU_REGISTER_SLAVE_MACROS_SVH

// same-cycle implication, checked out of reset
`define MRS_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define MRS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/mrs_pkg.sv
package mrs_pkg;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_HDR,
		ST_LEN,
		ST_CRC,
		ST_CHECK,
		ST_EXEC,
		ST_WR_HI,
		ST_WR_LO,
		ST_WR_DO,
		ST_BYTE,
		ST_FETCH
	} state_t;

	typedef enum logic [1:0] {
		RSP_READ,
		RSP_EXC,
		RSP_ECHO,
		RSP_WMULT
	} rsp_kind_t;

	typedef struct packed {
		logic        en;
		logic [15:0] addr;
		logic [15:0] data;
	} reg_wr_t;

	localparam logic [7:0]  FN_READ_HOLD   = 8'h03;
	localparam logic [7:0]  FN_READ_INPUT  = 8'h04;
	localparam logic [7:0]  FN_WRITE_ONE   = 8'h06;
	localparam logic [7:0]  FN_WRITE_MULTI = 8'h10;
	localparam logic [7:0]  EXC_FUNC       = 8'h01;
	localparam logic [7:0]  EXC_ADDR       = 8'h02;
	localparam logic [7:0]  EXC_FLAG       = 8'h80;
	localparam logic [15:0] CRC_POLY       = 16'hA001;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] MAX_SLAVE      = 16'd247;
	localparam logic [7:0]  DEFAULT_SLAVE  = 8'd1;
	localparam logic [15:0] ADDR_REG       = 16'h0091;
	localparam logic [15:0] RO_LO          = 16'h0040;
	localparam logic [15:0] RO_HI          = 16'h008F;
	localparam logic [15:0] PARAM_LO       = 16'h0090;
	localparam logic [15:0] PARAM_HI       = 16'h00BF;
	localparam int          HDR_BYTES      = 8;

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] x;
		x = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
		end
		return x;
	endfunction

endpackage

FILE: rtl/mrs_if.sv
interface mrs_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface mrs_tx_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte_first;
	logic [7:0] tx_byte_second;
	logic [1:0] tx_count;
	logic       last_of_frame;
	logic       params_changed;
	modport source(output valid, output tx_byte_first, output tx_byte_second,
		output tx_count, output last_of_frame, output params_changed, input ready);
	modport sink(input valid, input tx_byte_first, input tx_byte_second,
		input tx_count, input last_of_frame, input params_changed, output ready);
endinterface

FILE: rtl/mrs_frame_buf.sv
module mrs_frame_buf #(
	parameter int FRAME_BYTES = 64
) (
	input  logic                           clk,
	input  logic                           wr_en,
	input  logic [7:0]                     wr_data,
	input  logic [$clog2(FRAME_BYTES)-1:0] head,
	input  logic [$clog2(FRAME_BYTES)-1:0] wr_pos,
	input  logic                           rd_en,
	input  logic [$clog2(FRAME_BYTES)-1:0] rd_pos,
	output logic [7:0]                     rd_data
);
	localparam int FW = $clog2(FRAME_BYTES);

	logic [7:0]    mem [FRAME_BYTES];
	logic [FW-1:0] wa;
	logic [FW-1:0] ra;

	// circular buffer, positions are relative to the oldest byte
	function automatic logic [FW-1:0] wrap(input logic [FW-1:0] h, input logic [FW-1:0] p);
		logic [FW:0] s;
		s = {1'b0, h} + {1'b0, p};
		if (s >= (FW+1)'(FRAME_BYTES)) begin
			s = s - (FW+1)'(FRAME_BYTES);
		end
		return s[FW-1:0];
	endfunction

	assign wa = wrap(head, wr_pos);
	assign ra = wrap(head, rd_pos);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wa] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[ra];
		end
	end
endmodule

FILE: rtl/mrs_reg_bank.sv
module mrs_reg_bank
	import mrs_pkg::*;
#(
	parameter int REG_WORDS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  reg_wr_t                      wr,
	input  logic                         rd_en,
	input  logic [$clog2(REG_WORDS)-1:0] rd_addr,
	output logic [15:0]                  rd_data,
	output logic                         busy,
	output logic [7:0]                   own_addr,
	output logic                         dirty
);
	localparam int AW = $clog2(REG_WORDS);

	logic [15:0]   mem [REG_WORDS];
	logic [AW-1:0] clr_q;
	logic          busy_q;
	logic [7:0]    own_q;
	logic          dirty_q;
	logic          skip;
	logic          do_wr;
	logic          is_addr_reg;
	logic [15:0]   val;
	logic          we;
	logic [AW-1:0] wa;
	logic [15:0]   wd;

	assign skip        = (wr.addr >= RO_LO) && (wr.addr <= RO_HI);
	assign do_wr       = wr.en && !skip;
	assign is_addr_reg = wr.addr == ADDR_REG;
	// a slave address of 0 or above MAX_SLAVE is replaced by the default address
	assign val = (is_addr_reg && ((wr.data == 16'd0) || (wr.data > MAX_SLAVE))) ?
		16'(DEFAULT_SLAVE) : wr.data;

	always_comb begin
		if (busy_q) begin
			we = 1'b1;
			wa = clr_q;
			wd = (16'(clr_q) == ADDR_REG) ? 16'(DEFAULT_SLAVE) : 16'd0;
		end else begin
			we = do_wr;
			wa = wr.addr[AW-1:0];
			wd = val;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			busy_q  <= 1'b1;
			own_q   <= DEFAULT_SLAVE;
			dirty_q <= 1'b0;
		end else begin
			if (busy_q) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == AW'(REG_WORDS - 1)) begin
					busy_q <= 1'b0;
				end
			end
			if (!busy_q && do_wr) begin
				if (is_addr_reg) begin
					own_q <= val[7:0];
				end
				if ((wr.addr >= PARAM_LO) && (wr.addr <= PARAM_HI)) begin
					dirty_q <= 1'b1;
				end
			end
		end
	end

	assign busy     = busy_q;
	assign own_addr = own_q;
	assign dirty    = dirty_q;
endmodule

FILE: rtl/modbus_rtu_register_slave.sv
// modbus rtu slave over a bank of 16-bit holding registers
// rx: one received serial byte per word; tx: response words of two bytes each
// (tx_count 1 marks a lone final byte, last_of_frame the final word of a frame)
// each byte is stored in a circular frame buffer; from 8 bytes on the header is
// read back and, once the frame length is reached, the crc is recomputed from
// the frame buffer one byte per cycle
// from the last request byte to the first response word the header is read back,
// the length checked, the crc scanned and checked and the request executed; a
// response then leaves one byte per cycle unless tx.ready stalls it, with a
// register read before each register word on reads; a multiple write passes
// through ST_WR_HI, ST_WR_LO and ST_WR_DO for each register written
// throughput: one rx byte per cycle for the first 7 bytes of a frame; from the
// 8th byte on rx.ready is low after each byte for the header read and length
// check, and once the length is reached for the crc scan; after a complete frame
// the next byte is taken once the response is fully handed to the output register
// reset: all REG_WORDS holding registers are cleared in one pass (the slave
// address to its default), rx.ready stays low during it; the frame buffer starts empty
// a stalled receiver holds the current tx word; the response generator waits,
// and rx is taken again once the last word sits in the output register
`include "modbus_rtu_register_slave_macros.svh"

module modbus_rtu_register_slave
	import mrs_pkg::*;
#(
	parameter int FRAME_BYTES    = 64,
	parameter int REG_WORDS      = 256,
	parameter int RESPONSE_BYTES = 128
) (
	input  logic clk,
	input  logic arst_n,
	mrs_rx_if.sink   rx,
	mrs_tx_if.source tx
);
	localparam int FW       = $clog2(FRAME_BYTES);
	localparam int AW       = $clog2(REG_WORDS);
	localparam int RLW      = $clog2(RESPONSE_BYTES + 1);
	localparam int MAX_READ = (RESPONSE_BYTES - 5) / 2;

	state_t        state_q, state_d;
	logic [FW-1:0] fill_q, head_q, ic_q, pos_s1, tot_q, k_q;
	logic          v_s1;
	logic [7:0]    hdr_q [HDR_BYTES];
	logic [15:0]   crc_q, want_q, wa_q;
	logic [7:0]    hi_q, first_q, code_q;
	rsp_kind_t     kind_q;
	logic [RLW-1:0] bi_q, len_q;
	logic [AW-1:0] rd_addr_q;
	logic          fetched_q;
	logic          tx_v_q, txl_q, txp_q;
	logic [7:0]    txf_q, txs_q;
	logic [1:0]    txc_q;

	// buffer and bank ports
	logic          fb_wr_en, fb_rd_en;
	logic [FW-1:0] fb_rd_pos;
	logic [7:0]    fb_rd;
	reg_wr_t       bank_wr;
	logic          bank_rd_en, bank_busy, bank_dirty;
	logic [15:0]   bank_rd;
	logic [7:0]    own_addr;

	logic [FW:0]   fill_inc, head_inc;
	logic [15:0]   a16, q16;
	logic [17:0]   tot_wide;
	logic          scan_issue, scan_last, addr_ok, read_bad, w6_bad, w16_bad, last_k;
	logic [16:0]   end_addr;
	logic [7:0]    tx_b;
	logic          at_crc, need_fetch, push, out_free, advance, lo_byte;

	mrs_frame_buf #(.FRAME_BYTES(FRAME_BYTES)) u_frame (
		.clk     (clk),
		.wr_en   (fb_wr_en),
		.wr_data (rx.rx_byte),
		.head    (head_q),
		.wr_pos  (fill_q),
		.rd_en   (fb_rd_en),
		.rd_pos  (fb_rd_pos),
		.rd_data (fb_rd)
	);

	mrs_reg_bank #(.REG_WORDS(REG_WORDS)) u_bank (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (bank_wr),
		.rd_en    (bank_rd_en),
		.rd_addr  (rd_addr_q),
		.rd_data  (bank_rd),
		.busy     (bank_busy),
		.own_addr (own_addr),
		.dirty    (bank_dirty)
	);

	assign fill_inc = {1'b0, fill_q} + (FW+1)'(1);
	assign head_inc = {1'b0, head_q} + (FW+1)'(1);
	assign a16      = {hdr_q[2], hdr_q[3]};
	assign q16      = {hdr_q[4], hdr_q[5]};
	assign tot_wide = (hdr_q[1] == FN_WRITE_MULTI) ? (18'd9 + {1'b0, q16, 1'b0}) : 18'd8;
	assign end_addr = {1'b0, a16} + {1'b0, q16};
	assign addr_ok  = hdr_q[0] == own_addr;
	assign read_bad = (q16 == 16'd0) || (end_addr > 17'(REG_WORDS)) || (q16 > 16'(MAX_READ));
	assign w6_bad   = {1'b0, a16} >= 17'(REG_WORDS);
	assign w16_bad  = (q16 == 16'd0) || (hdr_q[6] != {q16[6:0], 1'b0})
		|| (end_addr > 17'(REG_WORDS));
	assign last_k   = (16'(k_q) + 16'd1) == q16;

	assign scan_issue = ((state_q == ST_HDR) && (ic_q < FW'(HDR_BYTES)))
		|| ((state_q == ST_CRC) && (ic_q < tot_q));
	assign scan_last  = (state_q == ST_HDR) ? (pos_s1 == FW'(HDR_BYTES - 1))
		: (pos_s1 == tot_q - FW'(1));

	// response byte generator
	assign at_crc = (kind_q != RSP_ECHO) && (bi_q >= len_q - RLW'(2));
	always_comb begin
		tx_b = 8'h00;
		if (at_crc) begin
			tx_b = (bi_q == len_q - RLW'(2)) ? crc_q[7:0] : crc_q[15:8];
		end else begin
			case (kind_q)
				RSP_READ: begin
					if (bi_q == RLW'(0)) begin
						tx_b = hdr_q[0];
					end else if (bi_q == RLW'(1)) begin
						tx_b = hdr_q[1];
					end else if (bi_q == RLW'(2)) begin
						tx_b = {hdr_q[5][6:0], 1'b0};
					end else begin
						tx_b = bi_q[0] ? bank_rd[15:8] : bank_rd[7:0];
					end
				end
				RSP_EXC: begin
					if (bi_q == RLW'(0)) begin
						tx_b = hdr_q[0];
					end else if (bi_q == RLW'(1)) begin
						tx_b = hdr_q[1] | EXC_FLAG;
					end else begin
						tx_b = code_q;
					end
				end
				default: tx_b = hdr_q[bi_q[2:0]];
			endcase
		end
	end

	assign need_fetch = (kind_q == RSP_READ) && (bi_q >= RLW'(3)) && !at_crc
		&& bi_q[0] && !fetched_q;
	assign lo_byte    = (kind_q == RSP_READ) && (bi_q >= RLW'(4)) && !at_crc && !bi_q[0];
	assign push       = bi_q[0] || (bi_q == len_q - RLW'(1));
	assign out_free   = !tx_v_q || tx.ready;
	assign advance    = (state_q == ST_BYTE) && !need_fetch && (!push || out_free);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (!bank_busy) state_d = ST_IDLE;
			ST_IDLE: begin
				if (rx.valid && (fill_inc != (FW+1)'(FRAME_BYTES))
					&& (fill_inc >= (FW+1)'(HDR_BYTES))) begin
					state_d = ST_HDR;
				end
			end
			ST_HDR: if (v_s1 && scan_last) state_d = ST_LEN;
			ST_LEN: state_d = (tot_wide > 18'(fill_q)) ? ST_IDLE : ST_CRC;
			ST_CRC: if (v_s1 && scan_last) state_d = ST_CHECK;
			ST_CHECK: state_d = (crc_q != want_q) ? ST_IDLE : ST_EXEC;
			ST_EXEC: begin
				if (!addr_ok) begin
					state_d = ST_IDLE;
				end else if ((hdr_q[1] == FN_WRITE_MULTI) && !w16_bad) begin
					state_d = ST_WR_HI;
				end else begin
					state_d = ST_BYTE;
				end
			end
			ST_WR_HI: state_d = ST_WR_LO;
			ST_WR_LO: state_d = ST_WR_DO;
			ST_WR_DO: state_d = last_k ? ST_BYTE : ST_WR_HI;
			ST_BYTE: begin
				if (need_fetch) begin
					state_d = ST_FETCH;
				end else if (advance && (bi_q == len_q - RLW'(1))) begin
					state_d = ST_IDLE;
				end
			end
			ST_FETCH: state_d = ST_BYTE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		rx.ready   = 1'b0;
		fb_wr_en   = 1'b0;
		fb_rd_en   = 1'b0;
		fb_rd_pos  = ic_q;
		bank_rd_en = 1'b0;
		bank_wr    = '0;
		unique case (state_q)
			ST_IDLE: begin
				rx.ready = 1'b1;
				fb_wr_en = rx.valid;
			end
			ST_HDR, ST_CRC: fb_rd_en = scan_issue;
			ST_WR_HI: begin
				fb_rd_en  = 1'b1;
				fb_rd_pos = FW'(7) + {k_q[FW-2:0], 1'b0};
			end
			ST_WR_LO: begin
				fb_rd_en  = 1'b1;
				fb_rd_pos = FW'(8) + {k_q[FW-2:0], 1'b0};
			end
			ST_WR_DO: bank_wr = '{en: 1'b1, addr: wa_q, data: {hi_q, fb_rd}};
			ST_EXEC: begin
				if (addr_ok && (hdr_q[1] == FN_WRITE_ONE) && !w6_bad) begin
					bank_wr = '{en: 1'b1, addr: a16, data: q16};
				end
			end
			ST_FETCH: bank_rd_en = 1'b1;
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			fill_q    <= '0;
			head_q    <= '0;
			ic_q      <= '0;
			v_s1      <= 1'b0;
			bi_q      <= '0;
			fetched_q <= 1'b0;
			tx_v_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= scan_issue;
			if (scan_issue) begin
				ic_q <= ic_q + FW'(1);
			end
			if (advance && push) begin
				tx_v_q <= 1'b1;
			end else if (tx.ready) begin
				tx_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					ic_q <= '0;
					if (rx.valid) begin
						fill_q <= (fill_inc == (FW+1)'(FRAME_BYTES)) ? '0 : fill_inc[FW-1:0];
					end
				end
				ST_LEN: ic_q <= '0;
				ST_CHECK: begin
					if (crc_q != want_q) begin
						// drop the oldest byte and retry on the next arrival
						head_q <= (head_inc == (FW+1)'(FRAME_BYTES)) ? '0 : head_inc[FW-1:0];
						fill_q <= fill_q - FW'(1);
					end else begin
						fill_q <= '0;
					end
				end
				ST_EXEC: begin
					bi_q      <= '0;
					fetched_q <= 1'b0;
				end
				ST_FETCH: fetched_q <= 1'b1;
				ST_BYTE: begin
					if (advance) begin
						bi_q <= bi_q + RLW'(1);
						if (lo_byte) begin
							fetched_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (v_s1 && (state_q == ST_HDR)) begin
			hdr_q[pos_s1[2:0]] <= fb_rd;
		end
		pos_s1 <= ic_q;
		if (advance && push) begin
			txf_q <= bi_q[0] ? first_q : tx_b;
			txs_q <= bi_q[0] ? tx_b : 8'h00;
			txc_q <= bi_q[0] ? 2'd2 : 2'd1;
			txl_q <= bi_q == len_q - RLW'(1);
			txp_q <= bank_dirty;
		end
		case (state_q)
			ST_LEN: begin
				tot_q <= tot_wide[FW-1:0];
				crc_q <= CRC_INIT;
			end
			ST_CRC: begin
				if (v_s1) begin
					if (pos_s1 < tot_q - FW'(2)) begin
						crc_q <= crc_byte(crc_q, fb_rd);
					end else if (pos_s1 == tot_q - FW'(2)) begin
						want_q[7:0] <= fb_rd;
					end else begin
						want_q[15:8] <= fb_rd;
					end
				end
			end
			ST_EXEC: begin
				crc_q     <= CRC_INIT;
				rd_addr_q <= a16[AW-1:0];
				wa_q      <= a16;
				k_q       <= '0;
				code_q    <= EXC_ADDR;
				unique case (hdr_q[1]) inside
					FN_READ_HOLD, FN_READ_INPUT: begin
						kind_q <= read_bad ? RSP_EXC : RSP_READ;
						len_q  <= read_bad ? RLW'(5) : RLW'(16'd5 + {q16[14:0], 1'b0});
					end
					FN_WRITE_ONE: begin
						kind_q <= w6_bad ? RSP_EXC : RSP_ECHO;
						len_q  <= w6_bad ? RLW'(5) : RLW'(8);
					end
					FN_WRITE_MULTI: begin
						kind_q <= w16_bad ? RSP_EXC : RSP_WMULT;
						len_q  <= w16_bad ? RLW'(5) : RLW'(8);
					end
					default: begin
						kind_q <= RSP_EXC;
						len_q  <= RLW'(5);
						code_q <= EXC_FUNC;
					end
				endcase
			end
			ST_WR_LO: hi_q <= fb_rd;
			ST_WR_DO: begin
				k_q  <= k_q + FW'(1);
				wa_q <= wa_q + 16'd1;
			end
			ST_BYTE: begin
				if (advance) begin
					if (!at_crc) begin
						crc_q <= crc_byte(crc_q, tx_b);
					end
					if (!bi_q[0]) begin
						first_q <= tx_b;
					end
					if (lo_byte) begin
						rd_addr_q <= rd_addr_q + AW'(1);
					end
				end
			end
			default: ;
		endcase
	end

	assign tx.valid          = tx_v_q;
	assign tx.tx_byte_first  = txf_q;
	assign tx.tx_byte_second = txs_q;
	assign tx.tx_count       = txc_q;
	assign tx.last_of_frame  = txl_q;
	assign tx.params_changed = txp_q;

	`MRS_ASSERT(a_no_rx_in_clear, rx.ready, !bank_busy, "rx taken during register clear")
	`MRS_ASSERT(a_short_is_last, tx.valid && (tx.tx_count == 2'd1), tx.last_of_frame, "single byte word not at end of frame")
	`MRS_ASSERT_NEXT(a_dirty_sticky, bank_dirty, bank_dirty, "parameter dirty flag cleared")
	`MRS_ASSERT(a_fetch_once, state_q == ST_FETCH, !fetched_q, "register word fetched twice")
endmodule
